FILE: rtl/core/bf3_pkg.sv
// Shared types and constants for the 3x3 edge-aware mean filter core.
// No dependencies; rtl/core uses it by scoped names, bar bf3_line_ram.
package bf3_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned MAX_SIDE    = 16;
  localparam int unsigned POS_W       = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W      = 5;
  localparam int unsigned SIDE_MIN    = 2;
  localparam int unsigned SIDE_RESET  = 8;
  localparam int unsigned LINE_W      = 2 * PIX_W;
  localparam int unsigned SUM_W       = 12;
  // floor(x/6) and floor(x/9) for x below 9*256, as (x*K) >> 15
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam int unsigned RECIP6      = 5462;
  localparam int unsigned RECIP9      = 3641;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SUM,
    ST_OUT
  } state_t;

  // which of the up to four released pixels, in release order
  typedef enum logic [1:0] {
    REL_A,   // (r-1, c-1)
    REL_B,   // (r-1, c)
    REL_C,   // (r,   c-1)
    REL_D    // (r,   c)
  } rel_t;

  typedef enum logic [1:0] {
    CNT_4,
    CNT_6,
    CNT_9
  } cnt_t;

  // one window column: [0] two rows up, [1] one row up, [2] current row
  typedef logic [2:0][PIX_W-1:0] col_t;

  typedef struct packed {
    logic [2:0] row_en;
    logic [2:0] col_en;
  } win_sel_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    cnt_t             cnt;
  } sum_job_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             low_r;
    logic             low_c;
    logic             last_r;
    logic             last_c;
  } job_t;

endpackage

FILE: rtl/core/bf3_pix_if.sv
// Input pixel channel: valid/ready handshake with one 8-bit pixel word.
// Depends on bf3_pkg for the pixel width.
interface bf3_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bf3_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

FILE: rtl/core/bf3_res_if.sv
// Result channel: valid/ready handshake with mean, position and end flags.
// Depends on bf3_pkg for field widths.
interface bf3_res_if;
  logic                      valid;
  logic                      ready;
  logic [bf3_pkg::PIX_W-1:0] mean_value;
  logic [bf3_pkg::POS_W-1:0] out_row;
  logic [bf3_pkg::POS_W-1:0] out_col;
  logic                      run_last;
  logic                      frame_last;

  modport source (output valid, output mean_value, output out_row, output out_col,
                  output run_last, output frame_last, input ready);
  modport sink   (input valid, input mean_value, input out_row, input out_col,
                  input run_last, input frame_last, output ready);
endinterface

FILE: rtl/core/bf3_cfg_if.sv
// Configuration write channel: valid/ready with the frame side register word.
// Depends on bf3_pkg for the register width.
interface bf3_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bf3_pkg::SIDE_W-1:0] frame_side;

  modport source (output valid, output frame_side, input ready);
  modport sink   (input valid, input frame_side, output ready);
endinterface

FILE: rtl/core/bf3_line_ram.sv
// Generic single-write, single-read synchronous RAM, read data registered.
// No dependencies; holds the two line stores side by side in one word.
module bf3_line_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bf3_window.sv
// 3x3 pixel window: three column registers shifted per pixel, plus the
// masked neighborhood sum. Depends on bf3_pkg.
module bf3_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  bf3_pkg::col_t     col_in,
  input  bf3_pkg::win_sel_t sel,
  output logic [bf3_pkg::SUM_W-1:0] sum
);

  bf3_pkg::col_t grid_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r[0] <= '0;
      grid_r[1] <= '0;
      grid_r[2] <= '0;
    end else if (shift) begin
      grid_r[0] <= grid_r[1];
      grid_r[1] <= grid_r[2];
      grid_r[2] <= col_in;
    end
  end

  always_comb begin
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (sel.col_en[c] && sel.row_en[r]) begin
          sum = sum + bf3_pkg::SUM_W'(grid_r[c][r]);
        end
      end
    end
  end

endmodule

FILE: rtl/core/bf3_mean_div.sv
// Divides a neighborhood sum by its pixel count (4, 6 or 9) through a
// shift or a constant reciprocal multiply. Depends on bf3_pkg.
module bf3_mean_div (
  input  bf3_pkg::sum_job_t          job,
  output logic [bf3_pkg::PIX_W-1:0]  mean
);

  localparam int unsigned PROD_W = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;
  localparam int unsigned LO     = bf3_pkg::RECIP_SHIFT;
  localparam int unsigned HI     = bf3_pkg::RECIP_SHIFT + bf3_pkg::PIX_W - 1;

  logic [PROD_W-1:0] prod6;
  logic [PROD_W-1:0] prod9;

  assign prod6 = PROD_W'(job.sum) * PROD_W'(bf3_pkg::RECIP6);
  assign prod9 = PROD_W'(job.sum) * PROD_W'(bf3_pkg::RECIP9);

  always_comb begin
    case (job.cnt)
      bf3_pkg::CNT_4: mean = job.sum[bf3_pkg::PIX_W+1:2];
      bf3_pkg::CNT_6: mean = prod6[HI:LO];
      bf3_pkg::CNT_9: mean = prod9[HI:LO];
      default:        mean = '0;
    endcase
  end

endmodule

FILE: rtl/core/box_filter_3x3_edge_mean_core.sv
// Top level of the 3x3 edge-aware mean filter: sequencer, position counters,
// output register. Depends on bf3_pkg, the three channel interfaces,
// bf3_line_ram, bf3_window and bf3_mean_div.
//
// Usage: pixels of a square frame enter on in_pix in raster order. cfg_wr
// sets the side length (clamped to 2..16) and restarts the frame; write it
// only while the core is idle. Each output word on out_res carries the
// truncated mean of the in-frame 3x3 neighborhood with its row and column;
// run_last marks the last word caused by one pixel, frame_last the
// bottom-right pixel of the frame.
// Timing: a pixel in row 0 or column 0 releases nothing. Any other pixel
// passes through the line store read, the window sum and the reciprocal
// multiply before its first word enters the output register; each further
// word of an edge pixel goes again through the same sum/divide path. The next
// pixel is taken in the cycle its predecessor's last word enters the output
// register. The line store is one RAM of {older, newer} words, read at
// acceptance and written back in the cycle after.
// Reset: frame side 8, counters and window zero, no word pending; the line
// store needs no clearing. A stalled receiver holds the output register and
// the sequencer waits; no word is lost.
module box_filter_3x3_edge_mean_core (
  input  logic clk,
  input  logic rst_n,
  bf3_pix_if.sink   in_pix,
  bf3_res_if.source out_res,
  bf3_cfg_if.sink   cfg_wr
);

  localparam int unsigned PW = bf3_pkg::PIX_W;
  localparam int unsigned QW = bf3_pkg::POS_W;
  localparam int unsigned SW = bf3_pkg::SIDE_W;

  bf3_pkg::state_t state_r, state_nxt;
  bf3_pkg::rel_t   rel_r, rel_nxt;
  bf3_pkg::job_t   job_r;

  logic [SW-1:0] side_r;
  logic [QW-1:0] row_r, col_r;
  logic [PW-1:0] pix_r;

  logic [SW-1:0] side_eff;
  logic [QW-1:0] side_m1;
  logic [QW-1:0] row_eff, col_eff;
  logic          last_r, last_c;

  logic in_fire, cfg_fire, out_free, rel_last, any_rel;

  logic [bf3_pkg::LINE_W-1:0] ram_rdata;
  logic [bf3_pkg::LINE_W-1:0] ram_wdata;
  bf3_pkg::col_t              win_col;
  bf3_pkg::win_sel_t          win_sel;
  logic [bf3_pkg::SUM_W-1:0]  win_sum;

  bf3_pkg::sum_job_t sj_r;
  bf3_pkg::cnt_t     cnt_sel;
  logic [PW-1:0]     mean;

  logic [QW-1:0] pend_row_r, pend_col_r, pend_row, pend_col;
  logic          pend_run_last_r, pend_frame_last_r;

  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_mean_r;
  logic [QW-1:0] out_row_r, out_col_r;
  logic          out_run_last_r, out_frame_last_r;

  // side clamp and counter sanity
  always_comb begin
    if (side_r < SW'(bf3_pkg::SIDE_MIN)) begin
      side_eff = SW'(bf3_pkg::SIDE_MIN);
    end else if (side_r > SW'(bf3_pkg::MAX_SIDE)) begin
      side_eff = SW'(bf3_pkg::MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
  end

  assign side_m1 = QW'(side_eff - SW'(1));
  assign row_eff = ({1'b0, row_r} >= side_eff) ? '0 : row_r;
  assign col_eff = ({1'b0, col_r} >= side_eff) ? '0 : col_r;
  assign last_r  = (row_eff == side_m1);
  assign last_c  = (col_eff == side_m1);
  assign any_rel = (row_eff != '0) && (col_eff != '0);

  assign in_fire  = in_pix.valid && in_pix.ready;
  assign cfg_fire = cfg_wr.valid && cfg_wr.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign cfg_wr.ready = 1'b1;

  // release sequence: A, then B on last column, C on last row, D on both
  always_comb begin
    rel_nxt  = rel_r;
    rel_last = 1'b1;
    case (rel_r)
      bf3_pkg::REL_A: begin
        if (job_r.last_c) begin
          rel_nxt  = bf3_pkg::REL_B;
          rel_last = 1'b0;
        end else if (job_r.last_r) begin
          rel_nxt  = bf3_pkg::REL_C;
          rel_last = 1'b0;
        end
      end
      bf3_pkg::REL_B: begin
        if (job_r.last_r) begin
          rel_nxt  = bf3_pkg::REL_C;
          rel_last = 1'b0;
        end
      end
      bf3_pkg::REL_C: begin
        if (job_r.last_c) begin
          rel_nxt  = bf3_pkg::REL_D;
          rel_last = 1'b0;
        end
      end
      default: begin
        rel_nxt  = rel_r;
        rel_last = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bf3_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = bf3_pkg::ST_RD;
        end
      end
      bf3_pkg::ST_RD: begin
        state_nxt = any_rel ? bf3_pkg::ST_SUM : bf3_pkg::ST_IDLE;
      end
      bf3_pkg::ST_SUM: begin
        state_nxt = bf3_pkg::ST_OUT;
      end
      bf3_pkg::ST_OUT: begin
        if (out_free) begin
          if (!rel_last) begin
            state_nxt = bf3_pkg::ST_SUM;
          end else if (in_fire) begin
            state_nxt = bf3_pkg::ST_RD;
          end else begin
            state_nxt = bf3_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = bf3_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_pix.ready = 1'b0;
    case (state_r)
      bf3_pkg::ST_IDLE: in_pix.ready = 1'b1;
      bf3_pkg::ST_OUT:  in_pix.ready = out_free && rel_last;
      default:          in_pix.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bf3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config and position counters; a config write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SW'(bf3_pkg::SIDE_RESET);
      row_r  <= '0;
      col_r  <= '0;
    end else if (cfg_fire) begin
      side_r <= cfg_wr.frame_side;
      row_r  <= '0;
      col_r  <= '0;
    end else if (state_r == bf3_pkg::ST_RD) begin
      if (last_c) begin
        col_r <= '0;
        row_r <= last_r ? '0 : row_eff + QW'(1);
      end else begin
        col_r <= col_eff + QW'(1);
        row_r <= row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r <= in_pix.pixel_value;
    end
  end

  // line store word: [15:8] two rows up, [7:0] one row up
  assign ram_wdata = {ram_rdata[PW-1:0], pix_r};

  bf3_line_ram #(
    .DEPTH (bf3_pkg::MAX_SIDE),
    .WIDTH (bf3_pkg::LINE_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (state_r == bf3_pkg::ST_RD),
    .waddr (col_eff),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (col_eff),
    .rdata (ram_rdata)
  );

  assign win_col[0] = ram_rdata[bf3_pkg::LINE_W-1:PW];
  assign win_col[1] = ram_rdata[PW-1:0];
  assign win_col[2] = pix_r;

  // row/col 0 of the window only on a centered release with two rows/cols
  // above inside the frame
  always_comb begin
    logic cr2, cc2;
    cr2 = (rel_r == bf3_pkg::REL_C) || (rel_r == bf3_pkg::REL_D);
    cc2 = (rel_r == bf3_pkg::REL_B) || (rel_r == bf3_pkg::REL_D);
    win_sel.row_en = {2'b11, !cr2 && !job_r.low_r};
    win_sel.col_en = {2'b11, !cc2 && !job_r.low_c};
    case ({win_sel.row_en[0], win_sel.col_en[0]})
      2'b11:   cnt_sel = bf3_pkg::CNT_9;
      2'b10:   cnt_sel = bf3_pkg::CNT_6;
      2'b01:   cnt_sel = bf3_pkg::CNT_6;
      default: cnt_sel = bf3_pkg::CNT_4;
    endcase
    pend_row = cr2 ? job_r.row : job_r.row - QW'(1);
    pend_col = cc2 ? job_r.col : job_r.col - QW'(1);
  end

  bf3_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (state_r == bf3_pkg::ST_RD),
    .col_in (win_col),
    .sel    (win_sel),
    .sum    (win_sum)
  );

  always_ff @(posedge clk) begin
    if (state_r == bf3_pkg::ST_RD) begin
      job_r.row    <= row_eff;
      job_r.col    <= col_eff;
      job_r.low_r  <= (row_eff < QW'(2));
      job_r.low_c  <= (col_eff < QW'(2));
      job_r.last_r <= last_r;
      job_r.last_c <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r <= bf3_pkg::REL_A;
    end else if (state_r == bf3_pkg::ST_RD) begin
      rel_r <= bf3_pkg::REL_A;
    end else if ((state_r == bf3_pkg::ST_OUT) && out_free) begin
      rel_r <= rel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bf3_pkg::ST_SUM) begin
      sj_r.sum          <= win_sum;
      sj_r.cnt          <= cnt_sel;
      pend_row_r        <= pend_row;
      pend_col_r        <= pend_col;
      pend_run_last_r   <= rel_last;
      pend_frame_last_r <= (pend_row == side_m1) && (pend_col == side_m1);
    end
  end

  bf3_mean_div u_mean_div (
    .job  (sj_r),
    .mean (mean)
  );

  // output register
  always_comb begin
    if ((state_r == bf3_pkg::ST_OUT) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == bf3_pkg::ST_OUT) && out_free) begin
      out_mean_r       <= mean;
      out_row_r        <= pend_row_r;
      out_col_r        <= pend_col_r;
      out_run_last_r   <= pend_run_last_r;
      out_frame_last_r <= pend_frame_last_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.mean_value = out_mean_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.run_last   = out_run_last_r;
  assign out_res.frame_last = out_frame_last_r;

endmodule

FILE: bench/box_filter_3x3_edge_mean_core_tb.sv
// Self-checking bench for the 3x3 edge-aware mean filter core: drives pixel frames and
// side register writes, predicts every output word and compares it field by field.
// Depends on bf3_pkg, the core and the bf3_pix_if, bf3_res_if and bf3_cfg_if interfaces.
module box_filter_3x3_edge_mean_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PW           = bf3_pkg::PIX_W;
  localparam int unsigned QW           = bf3_pkg::POS_W;
  localparam int unsigned SW           = bf3_pkg::SIDE_W;
  localparam int unsigned NMAX         = bf3_pkg::MAX_SIDE;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_PIXELS = 50;
  localparam int unsigned DIR_LEN      = 30;

  typedef enum logic {STEP_SIDE, STEP_PIXEL} step_kind_t;

  typedef struct packed {
    step_kind_t    kind;
    logic [PW-1:0] value;
    logic          typed;   // every word of this pixel has this mean
    logic [PW-1:0] mean;
  } dir_step_t;

  typedef struct packed {
    logic [PW-1:0] mean;
    logic [QW-1:0] row;
    logic [QW-1:0] col;
    logic          run_last;
    logic          frame_last;
  } mean_word_t;

  logic clk;
  logic rst_n;

  bf3_pix_if pix_if();
  bf3_res_if res_if();
  bf3_cfg_if cfg_if();

  box_filter_3x3_edge_mean_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_res(res_if),
    .cfg_wr (cfg_if)
  );

  // filter state as the bench sees it
  logic [SW-1:0] side_reg;
  logic [PW-1:0] line_old [NMAX];
  logic [PW-1:0] line_new [NMAX];
  logic [PW-1:0] win_cols [6];
  int unsigned   row_pos, col_pos;
  mean_word_t    pending_means[$];

  dir_step_t     dir_table [DIR_LEN];
  int unsigned   src_idle_pct, snk_stall_pct;
  int unsigned   hold_left;
  bit            hold_req;
  int unsigned   errors, words_checked, pixels_sent, side_writes, cycle_count;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned side_eff(input logic [SW-1:0] v);
    if (v < bf3_pkg::SIDE_MIN) return bf3_pkg::SIDE_MIN;
    if (v > NMAX) return NMAX;
    return v;
  endfunction

  // nb holds the 3x3 window row-major; rows/cols below lowr/lowc are outside the frame
  function automatic logic [PW-1:0] nbhd_mean(input logic [8:0][PW-1:0] nb, input int cr,
                                               input int cc, input int lowr, input int lowc);
    int r0, r1, c0, c1, sum, cnt;
    r0 = (cr - 1 < lowr) ? lowr : cr - 1;
    c0 = (cc - 1 < lowc) ? lowc : cc - 1;
    r1 = (cr + 1 > 2) ? 2 : cr + 1;
    c1 = (cc + 1 > 2) ? 2 : cc + 1;
    sum = 0;
    cnt = 0;
    for (int i = r0; i <= r1; i++) begin
      for (int j = c0; j <= c1; j++) begin
        sum += nb[i*3 + j];
        cnt++;
      end
    end
    return PW'(sum / cnt);
  endfunction

  function automatic mean_word_t make_word(input logic [PW-1:0] m, input int unsigned row,
                                           input int unsigned col, input int unsigned s);
    mean_word_t w;
    w.mean       = m;
    w.row        = row[QW-1:0];
    w.col        = col[QW-1:0];
    w.run_last   = 1'b0;
    w.frame_last = (row == s - 1) && (col == s - 1);
    return w;
  endfunction

  function automatic logic [SW-1:0] pick_side();
    case ($urandom_range(11))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd17;
      4: return 5'd31;
      default: return SW'(2 + $urandom_range(4));
    endcase
  endfunction

  // advance the filter state by one accepted pixel and queue the words it releases
  task automatic predict_pixel(input logic [PW-1:0] pix, input logic typed,
                               input logic [PW-1:0] typed_mean);
    int unsigned s, r, c, n;
    int lowr, lowc;
    logic [8:0][PW-1:0] nb;
    logic lastr, lastc;
    mean_word_t words[$];
    mean_word_t w;
    s = side_eff(side_reg);
    r = (row_pos >= s) ? 0 : row_pos;
    c = (col_pos >= s) ? 0 : col_pos;
    for (int k = 0; k < 3; k++) begin
      nb[k*3]     = win_cols[k];
      nb[k*3 + 1] = win_cols[3 + k];
    end
    nb[2] = line_old[c];
    nb[5] = line_new[c];
    nb[8] = pix;
    line_old[c] = line_new[c];
    line_new[c] = pix;
    for (int k = 0; k < 3; k++) begin
      win_cols[k]     = win_cols[3 + k];
      win_cols[3 + k] = nb[k*3 + 2];
    end
    lowr  = (r >= 2) ? 0 : 1;
    lowc  = (c >= 2) ? 0 : 1;
    lastr = (r == s - 1);
    lastc = (c == s - 1);
    if (r >= 1 && c >= 1) begin
      words.push_back(make_word(nbhd_mean(nb, 1, 1, lowr, lowc), r - 1, c - 1, s));
      if (lastc) words.push_back(make_word(nbhd_mean(nb, 1, 2, lowr, lowc), r - 1, c, s));
      if (lastr) begin
        words.push_back(make_word(nbhd_mean(nb, 2, 1, lowr, lowc), r, c - 1, s));
        if (lastc) words.push_back(make_word(nbhd_mean(nb, 2, 2, lowr, lowc), r, c, s));
      end
    end
    n = words.size();
    for (int i = 0; i < n; i++) begin
      w = words[i];
      w.run_last = (i == n - 1);
      if (typed) w.mean = typed_mean;
      pending_means.push_back(w);
    end
    if (lastc) begin
      col_pos = 0;
      row_pos = lastr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input logic [PW-1:0] pix, input logic typed,
                            input logic [PW-1:0] typed_mean);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= pix;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_pixel(pix, typed, typed_mean);
    pixels_sent++;
    @(negedge clk);
  endtask

  // side register only changes once the core has gone quiet
  task automatic write_side(input logic [SW-1:0] v);
    while (pending_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.frame_side <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    side_reg = v;
    row_pos  = 0;
    col_pos  = 0;
    side_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got, input mean_word_t w);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch for pixel (%0d,%0d): expected %0d, got %0d",
               $time, name, w.row, w.col, want, got);
    end
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    mean_word_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_means.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: mean %0d row %0d col %0d run_last %0b frame_last %0b",
                 $time, res_if.mean_value, res_if.out_row, res_if.out_col,
                 res_if.run_last, res_if.frame_last);
      end else begin
        want = pending_means.pop_front();
        words_checked++;
        check_field("mean_value", want.mean, res_if.mean_value, want);
        check_field("out_row", want.row, res_if.out_row, want);
        check_field("out_col", want.col, res_if.out_col, want);
        check_field("run_last", want.run_last, res_if.run_last, want);
        check_field("frame_last", want.frame_last, res_if.frame_last, want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding",
               $time, cycle_count, pending_means.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned budget, n_full, n_send, s, mode;
    bit first;
    logic [SW-1:0] v;
    logic [PW-1:0] p;

    rst_n              <= 1'b0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_value <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.frame_side  <= '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    errors        = 0;
    words_checked = 0;
    pixels_sent   = 0;
    side_writes   = 0;
    cycle_count   = 0;
    side_reg      = bf3_pkg::SIDE_RESET;
    row_pos       = 0;
    col_pos       = 0;
    foreach (line_old[i]) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;

    // smallest frames with flat content, clamped sides, then a flat 3x3 frame
    dir_table = '{
      '{STEP_SIDE,  8'd2,   1'b0, 8'd0},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd0,   1'b1, 8'd0},
      '{STEP_PIXEL, 8'd0,   1'b1, 8'd0},
      '{STEP_PIXEL, 8'd0,   1'b1, 8'd0},
      '{STEP_PIXEL, 8'd0,   1'b1, 8'd0},
      '{STEP_SIDE,  8'd0,   1'b0, 8'd0},
      '{STEP_PIXEL, 8'd1,   1'b0, 8'd0},
      '{STEP_PIXEL, 8'd128, 1'b0, 8'd0},
      '{STEP_PIXEL, 8'd127, 1'b0, 8'd0},
      '{STEP_PIXEL, 8'd254, 1'b0, 8'd0},
      '{STEP_SIDE,  8'd1,   1'b0, 8'd0},
      '{STEP_PIXEL, 8'd170, 1'b0, 8'd0},
      '{STEP_PIXEL, 8'd85,  1'b0, 8'd0},
      '{STEP_PIXEL, 8'd255, 1'b0, 8'd0},
      '{STEP_PIXEL, 8'd0,   1'b0, 8'd0},
      '{STEP_SIDE,  8'd3,   1'b0, 8'd0},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_PIXEL, 8'd255, 1'b1, 8'd255},
      '{STEP_SIDE,  8'd17,  1'b0, 8'd0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == STEP_SIDE) begin
        pix_if.valid <= 1'b0;
        write_side(dir_table[i].value[SW-1:0]);
      end else begin
        send_pixel(dir_table[i].value, dir_table[i].typed, dir_table[i].mean);
      end
    end

    // phases: no idling, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      budget = 0;
      first  = 1'b1;
      while (budget < PHASE_PIXELS) begin
        v = (ph == 0 && first) ? 5'd31 : pick_side();
        pix_if.valid <= 1'b0;
        write_side(v);
        s      = side_eff(v);
        n_full = s * s;
        if ($urandom_range(3) == 0) begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end else begin
          case (ph)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
            default: begin src_idle_pct = 13; snk_stall_pct = 13; end
          endcase
        end
        if (ph == 0 && first) begin
          // three rows of the largest frame, receiver held off so the core backs up
          n_send   = 3 * s;
          hold_req = 1'b1;
        end else if (s >= 8) begin
          n_send = $urandom_range(3 * s, 1);
        end else if ($urandom_range(4) == 0) begin
          n_send = $urandom_range(n_full - 1, 1);
        end else begin
          n_send = n_full;
        end
        mode = $urandom_range(5);
        for (int k = 0; k < n_send; k++) begin
          case (mode)
            0: p = 8'd255;
            1: p = 8'd0;
            2: p = (((k % s) + (k / s)) % 2 == 1) ? 8'd255 : 8'd0;
            default: p = PW'($urandom_range(255));
          endcase
          send_pixel(p, 1'b0, '0);
        end
        budget += n_send;
        first = 1'b0;
      end
    end

    pix_if.valid <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    while (pending_means.size() != 0) @(negedge clk);
    repeat (4 * DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d pixels in %0d frames with sides 0..31, edge and corner windows,",
             pixels_sent, side_writes);
    $display("aborted frames and a long output stall; %0d words checked, %0d errors",
             words_checked, errors);
    if (errors == 0 && pending_means.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
